### rtl/lps_pkg.sv
// Shared types, walk mode codes and coordinate helper for the line pixel stepper.
package lps_pkg;

  localparam int CoordBits = 16;
  localparam int CoordShift = 16 - CoordBits;

  localparam logic [2:0] MODE_VERT  = 3'd0;
  localparam logic [2:0] MODE_HORZ  = 3'd1;
  localparam logic [2:0] MODE_XMAJ  = 3'd2;
  localparam logic [2:0] MODE_YUP   = 3'd3;
  localparam logic [2:0] MODE_YDOWN = 3'd4;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [31:0]        line_color;
  } lps_req_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        pixel_value;
    logic               on_screen;
    logic               last_pixel;
  } lps_pixel_t;

  typedef struct packed {
    logic               busy;
    logic [2:0]         walk_mode;
    logic signed [15:0] major_pos;
    logic signed [15:0] minor_pos;
    logic signed [15:0] stop_pos;
    logic signed [18:0] err_acc;
    logic signed [17:0] delta_x;
    logic signed [17:0] delta_y;
    logic [31:0]        held_color;
  } lps_walk_t;

  function automatic logic signed [15:0] coord_of(input logic [15:0] v);
    logic signed [15:0] t;
    t = $signed(v << CoordShift);
    return t >>> CoordShift;
  endfunction

endpackage

### rtl/lps_setup.sv
// Start decode: endpoint swap, deltas and walk mode selection for a new line.
module lps_setup
  import lps_pkg::*;
(
  input  lps_req_t  req,
  output lps_walk_t walk
);

  logic signed [15:0] xa, ya, xb, yb;
  logic signed [15:0] x0, y0, x1, y1;
  logic               swap;
  logic signed [16:0] dx, dy, ady;

  always_comb begin
    xa = coord_of(req.x_start);
    ya = coord_of(req.y_start);
    xb = coord_of(req.x_end);
    yb = coord_of(req.y_end);
    swap = xb < xa;
    x0 = swap ? xb : xa;
    y0 = swap ? yb : ya;
    x1 = swap ? xa : xb;
    y1 = swap ? ya : yb;
    dx = 17'(x1) - 17'(x0);
    dy = 17'(y1) - 17'(y0);
    ady = dy[16] ? -dy : dy;

    walk.busy       = 1'b1;
    walk.err_acc    = '0;
    walk.delta_x    = 18'(dx);
    walk.delta_y    = 18'(dy);
    walk.held_color = req.line_color;

    if (dx == 17'sd0) begin
      walk.walk_mode = MODE_VERT;
      walk.minor_pos = x0;
      walk.major_pos = (y0 < y1) ? y0 : y1;
      walk.stop_pos  = (y0 < y1) ? y1 : y0;
    end else if (dy == 17'sd0) begin
      walk.walk_mode = MODE_HORZ;
      walk.major_pos = x0;
      walk.stop_pos  = x1;
      walk.minor_pos = y0;
    end else if (dx >= ady) begin
      walk.walk_mode = MODE_XMAJ;
      walk.major_pos = x0;
      walk.stop_pos  = x1;
      walk.minor_pos = y0;
    end else begin
      walk.walk_mode = dy[16] ? MODE_YDOWN : MODE_YUP;
      walk.major_pos = y0;
      walk.stop_pos  = y1;
      walk.minor_pos = x0;
    end
  end

endmodule

### rtl/lps_step.sv
// Step logic: current pixel, visibility and last flags, and the next walk state.
module lps_step
  import lps_pkg::*;
(
  input  lps_walk_t   walk,
  input  logic [14:0] screen_width,
  input  logic [14:0] screen_height,
  output lps_pixel_t  pixel,
  output lps_walk_t   walk_next
);

  logic signed [15:0] px, py;
  logic               last;
  logic               y_walk;
  logic signed [19:0] sum_y, sum_x;
  logic signed [20:0] e2_y, e2_x, dx21, dy21;

  always_comb begin
    y_walk = (walk.walk_mode == MODE_VERT) || (walk.walk_mode == MODE_YUP) ||
             (walk.walk_mode == MODE_YDOWN);
    px = y_walk ? walk.minor_pos : walk.major_pos;
    py = y_walk ? walk.major_pos : walk.minor_pos;
    last = walk.major_pos == walk.stop_pos;

    pixel.pixel_x     = px;
    pixel.pixel_y     = py;
    pixel.pixel_value = walk.held_color;
    pixel.on_screen   = !px[15] && !py[15] && (px[14:0] < screen_width) &&
                        (py[14:0] < screen_height);
    pixel.last_pixel  = last;

    sum_y = 20'(walk.err_acc) + 20'(walk.delta_y);
    sum_x = 20'(walk.err_acc) + 20'(walk.delta_x);
    e2_y  = 21'(sum_y) <<< 1;
    e2_x  = 21'(sum_x) <<< 1;
    dx21  = 21'(walk.delta_x);
    dy21  = 21'(walk.delta_y);

    walk_next = walk;
    if (last) begin
      walk_next.busy = 1'b0;
    end else begin
      case (walk.walk_mode)
        MODE_XMAJ: begin
          walk_next.major_pos = walk.major_pos + 16'sd1;
          walk_next.err_acc   = 19'(sum_y);
          if (!walk.delta_y[17]) begin
            if (e2_y >= dx21) begin
              walk_next.minor_pos = walk.minor_pos + 16'sd1;
              walk_next.err_acc   = 19'(sum_y - 20'(walk.delta_x));
            end
          end else if (-e2_y >= dx21) begin
            walk_next.minor_pos = walk.minor_pos - 16'sd1;
            walk_next.err_acc   = 19'(sum_y + 20'(walk.delta_x));
          end
        end
        MODE_YUP: begin
          walk_next.major_pos = walk.major_pos + 16'sd1;
          walk_next.err_acc   = 19'(sum_x);
          if (e2_x >= dy21) begin
            walk_next.minor_pos = walk.minor_pos + 16'sd1;
            walk_next.err_acc   = 19'(sum_x - 20'(walk.delta_y));
          end
        end
        MODE_YDOWN: begin
          walk_next.major_pos = walk.major_pos - 16'sd1;
          walk_next.err_acc   = 19'(sum_x);
          if (-e2_x <= dy21) begin
            walk_next.minor_pos = walk.minor_pos + 16'sd1;
            walk_next.err_acc   = 19'(sum_x + 20'(walk.delta_y));
          end
        end
        default: begin
          walk_next.major_pos = walk.major_pos + 16'sd1;
        end
      endcase
    end
  end

endmodule

### rtl/line_pixel_stepper_unit.sv
// Top level of the line pixel stepper: walk state, screen registers and pixel output register.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_ready  in_data  (lps_req_t)
//   out       pixel      out_valid/out_ready  out_data (lps_pixel_t)
//   cfg       write      cfg_wr_en            cfg_index, cfg_data
//
// One request per clock while in_ready is high; a step on a busy walk yields its pixel in the
// output register the next cycle, formed combinationally from the walk state register.
// A request is taken whenever the output register is empty or being drained.
// Reset clears the walk (idle) and loads screen size 640 by 480.
module line_pixel_stepper_unit
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lps_req_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lps_pixel_t  out_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);

  lps_walk_t   walk, walk_start, walk_step;
  lps_pixel_t  pixel;
  logic [14:0] screen_width, screen_height;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lps_setup u_setup (
    .req  (in_data),
    .walk (walk_start)
  );

  lps_step u_step (
    .walk          (walk),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pixel         (pixel),
    .walk_next     (walk_step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 15'd640;
      screen_height <= 15'd480;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH:  screen_width  <= cfg_data;
        CFG_HEIGHT: screen_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (accept) begin
      if (in_data.kind == KIND_START) begin
        walk <= walk_start;
      end else if (walk.busy) begin
        walk <= walk_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.kind == KIND_STEP && walk.busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.kind == KIND_STEP && walk.busy) begin
      out_data <= pixel;
    end
  end

endmodule

### tb/line_pixel_stepper_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_pixel_stepper_unit: directed and random line walks.
module line_pixel_stepper_unit_tb;
  import lps_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int RandomItems = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lps_req_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lps_pixel_t  out_data;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_WIDTH;
  logic [14:0] cfg_data = '0;

  bit                 walk_busy = 1'b0;
  logic [2:0]         walk_mode_m = MODE_VERT;
  logic signed [15:0] major_m = '0;
  logic signed [15:0] minor_m = '0;
  logic signed [15:0] stop_m = '0;
  logic signed [18:0] err_m = '0;
  logic signed [17:0] dx_m = '0;
  logic signed [17:0] dy_m = '0;
  logic [31:0]        color_m = '0;
  logic [14:0]        width_m = 15'd640;
  logic [14:0]        height_m = 15'd480;

  lps_pixel_t pixel_q[$];
  lps_pixel_t want_pixel;
  int mismatch_count = 0;
  int live_items = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;

  line_pixel_stepper_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic int to_coord(logic [15:0] v);
    int s;
    s = int'(v) & ((1 << CoordBits) - 1);
    if (s >= (1 << (CoordBits - 1))) s -= (1 << CoordBits);
    return s;
  endfunction

  function automatic logic [14:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 15'd0;
    end else if (r < 16) begin
      return 15'd1;
    end else if (r < 24) begin
      return 15'h7fff;
    end
    return 15'($urandom_range(2, 1000));
  endfunction

  function automatic lps_req_t step_req();
    lps_req_t r;
    r.kind = KIND_STEP;
    r.x_start = 16'($urandom);
    r.y_start = 16'($urandom);
    r.x_end = 16'($urandom);
    r.y_end = 16'($urandom);
    r.line_color = $urandom;
    return r;
  endfunction

  task automatic load_line(lps_req_t r);
    int xa, ya, xb, yb, t, dx, dy, ady;
    xa = to_coord(r.x_start);
    ya = to_coord(r.y_start);
    xb = to_coord(r.x_end);
    yb = to_coord(r.y_end);
    if (xb < xa) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    dx = xb - xa;
    dy = yb - ya;
    ady = (dy < 0) ? -dy : dy;
    color_m = r.line_color;
    err_m = '0;
    dx_m = dx[17:0];
    dy_m = dy[17:0];
    walk_busy = 1'b1;
    if (dx == 0) begin
      walk_mode_m = MODE_VERT;
      minor_m = xa[15:0];
      major_m = (ya < yb) ? ya[15:0] : yb[15:0];
      stop_m = (ya < yb) ? yb[15:0] : ya[15:0];
    end else if (dy == 0) begin
      walk_mode_m = MODE_HORZ;
      major_m = xa[15:0];
      stop_m = xb[15:0];
      minor_m = ya[15:0];
    end else if (dx >= ady) begin
      walk_mode_m = MODE_XMAJ;
      major_m = xa[15:0];
      stop_m = xb[15:0];
      minor_m = ya[15:0];
    end else begin
      walk_mode_m = (dy > 0) ? MODE_YUP : MODE_YDOWN;
      major_m = ya[15:0];
      stop_m = yb[15:0];
      minor_m = xa[15:0];
    end
  endtask

  task automatic advance_walk(lps_req_t r);
    int px, py, e, dxi, dyi;
    bit last_f, vis;
    lps_pixel_t p;
    if (r.kind == KIND_START) begin
      load_line(r);
      live_items++;
      return;
    end
    if (!walk_busy) return;
    live_items++;
    if (walk_mode_m == MODE_VERT || walk_mode_m == MODE_YUP || walk_mode_m == MODE_YDOWN) begin
      px = int'(minor_m);
      py = int'(major_m);
    end else begin
      px = int'(major_m);
      py = int'(minor_m);
    end
    last_f = (major_m == stop_m);
    vis = (px >= 0) && (py >= 0) && (px < int'(width_m)) && (py < int'(height_m));
    p.pixel_x = px[15:0];
    p.pixel_y = py[15:0];
    p.pixel_value = color_m;
    p.on_screen = vis;
    p.last_pixel = last_f;
    pixel_q.push_back(p);
    if (last_f) begin
      walk_busy = 1'b0;
      return;
    end
    e = int'(err_m);
    dxi = int'(dx_m);
    dyi = int'(dy_m);
    case (walk_mode_m)
      MODE_XMAJ: begin
        e += dyi;
        if (dyi >= 0) begin
          if (e * 2 >= dxi) begin
            minor_m = minor_m + 16'sd1;
            e -= dxi;
          end
        end else if (-(e * 2) >= dxi) begin
          minor_m = minor_m - 16'sd1;
          e += dxi;
        end
        major_m = major_m + 16'sd1;
      end
      MODE_YUP: begin
        e += dxi;
        if (e * 2 >= dyi) begin
          minor_m = minor_m + 16'sd1;
          e -= dyi;
        end
        major_m = major_m + 16'sd1;
      end
      MODE_YDOWN: begin
        e += dxi;
        if (-(e * 2) <= dyi) begin
          minor_m = minor_m + 16'sd1;
          e += dyi;
        end
        major_m = major_m - 16'sd1;
      end
      default: begin
        major_m = major_m + 16'sd1;
      end
    endcase
    err_m = e[18:0];
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
  endtask

  task automatic send_req(lps_req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_walk(r);
    if (tx_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic draw_line(int xs, int ys, int xe, int ye, logic [31:0] color, int nsteps);
    lps_req_t r;
    r.kind = KIND_START;
    r.x_start = xs[15:0];
    r.y_start = ys[15:0];
    r.x_end = xe[15:0];
    r.y_end = ye[15:0];
    r.line_color = color;
    send_req(r);
    repeat (nsteps) send_req(step_req());
  endtask

  // hold the sender until every pixel has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WIDTH) begin
      width_m = val;
    end else begin
      height_m = val;
    end
    @(posedge clk);
  endtask

  task automatic set_screen(logic [14:0] w, logic [14:0] h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic test_idle_step();
    send_req(step_req());
    send_req(step_req());
    wait_idle();
  endtask

  task automatic test_walk_modes();
    draw_line(639, 479, 639, 479, 32'hffff_ffff, 2);
    draw_line(5, 1, 5, 0, 32'h0000_0000, 2);
    draw_line(32767, 7, 32766, 7, $urandom, 2);
    draw_line(-32768, 0, -32766, -1, $urandom, 3);
    draw_line(0, -32768, 1, -32766, $urandom, 3);
    draw_line(0, 32767, 1, 32765, $urandom, 3);
    // diagonal, cut short by the next start
    draw_line(3, 3, 6, 6, $urandom, 1);
    draw_line(638, 478, 641, 480, $urandom, 4);
    wait_idle();
  endtask

  task automatic test_screen_limits();
    set_screen(15'd0, 15'd0);
    draw_line(0, 0, 1, 0, $urandom, 2);
    wait_idle();
    set_screen(15'h7fff, 15'h7fff);
    draw_line(32766, 32766, 32767, 32767, $urandom, 2);
    wait_idle();
    set_screen(15'd1, 15'd1);
    draw_line(0, 0, 1, 0, $urandom, 2);
    wait_idle();
  endtask

  task automatic test_random_lines();
    int first, next_cfg, r, span_x, span_y, bx, by, lx, ly, xe, ye, nsteps;
    first = live_items;
    next_cfg = live_items + 250;
    while (live_items - first < RandomItems) begin
      if (live_items >= next_cfg) begin
        wait_idle();
        set_screen(pick_dim(), pick_dim());
        tx_gaps = ($urandom_range(0, 9) < 7);
        rx_stalls = ($urandom_range(0, 9) < 7);
        next_cfg = live_items + 250;
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        span_x = ((width_m > 1000) ? 1000 : int'(width_m)) + 80;
        span_y = ((height_m > 1000) ? 1000 : int'(height_m)) + 80;
        bx = int'($urandom_range(0, span_x)) - 40;
        by = int'($urandom_range(0, span_y)) - 40;
        lx = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 60 : 12);
        ly = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 60 : 12);
        xe = $urandom_range(0, 1) ? bx + lx : bx - lx;
        ye = $urandom_range(0, 1) ? by + ly : by - ly;
        nsteps = ((lx > ly) ? lx : ly) + 1;
        case ($urandom_range(0, 9))
          0: nsteps = $urandom_range(0, nsteps - 1);
          1: nsteps += $urandom_range(1, 3);
          default: ;
        endcase
        draw_line(bx, by, xe, ye, $urandom, nsteps);
      end else if (r < 92) begin
        draw_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1, 6));
      end else if (r < 97) begin
        send_req(step_req());
      end else begin
        wait_idle();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_stalls && $urandom_range(0, 99) < 25) rx_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel", {out_data.pixel_x, out_data.pixel_y}, '0);
      end else begin
        want_pixel = pixel_q.pop_front();
        if (out_data.pixel_x !== want_pixel.pixel_x)
          report_mismatch("pixel_x", 32'(out_data.pixel_x), 32'(want_pixel.pixel_x));
        if (out_data.pixel_y !== want_pixel.pixel_y)
          report_mismatch("pixel_y", 32'(out_data.pixel_y), 32'(want_pixel.pixel_y));
        if (out_data.pixel_value !== want_pixel.pixel_value)
          report_mismatch("pixel_value", out_data.pixel_value, want_pixel.pixel_value);
        if (out_data.on_screen !== want_pixel.on_screen)
          report_mismatch("on_screen", 32'(out_data.on_screen),
                          32'(want_pixel.on_screen));
        if (out_data.last_pixel !== want_pixel.last_pixel)
          report_mismatch("last_pixel", 32'(out_data.last_pixel),
                          32'(want_pixel.last_pixel));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("line_pixel_stepper_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_step();
    test_walk_modes();
    test_screen_limits();
    test_random_lines();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("line_pixel_stepper_unit_tb OK");
    end else begin
      $display("line_pixel_stepper_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
